[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpd assertion failed");

// Next-cycle implication, disabled while in reset.
`define CPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpd assertion failed");

`endif

[rtl/cpd_pkg.sv]
// Types and constants of the chunk packet deframer.
// No dependencies; imported by every module of the block.
package cpd_pkg;

    localparam int unsigned HDR_BODY = 18;

    localparam logic [31:0] MAGIC_RESET   = 32'hDEAD_BEEF;
    localparam logic [7:0]  VERSION_RESET = 8'h01;
    localparam logic [7:0]  IMAGE_RESET   = 8'h02;

    typedef enum logic [1:0] {
        KIND_GOOD    = 2'd0,
        KIND_REJECT  = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_CHECKSUM = 2'd1,
        CAUSE_MAGIC    = 2'd2,
        CAUSE_VERSION  = 2'd3
    } cause_t;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_IMAGE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  image_type;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        cause_t      cause;
        logic [7:0]  message_type;
        logic [31:0] chunk_index;
        logic [31:0] chunk_total;
        logic [31:0] payload_length;
        logic        final_chunk;
        logic [7:0]  payload_value;
        logic        last_payload_byte;
    } result_t;

endpackage

[rtl/cpd_regs.sv]
// APB-style configuration registers: magic, version, image chunk type.
// Depends on cpd_pkg.
module cpd_regs
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx = reg_idx_t'(paddr[3:2]);
    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic      <= MAGIC_RESET;
            cfg_reg.version    <= VERSION_RESET;
            cfg_reg.image_type <= IMAGE_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_MAGIC:   cfg_reg.magic      <= pwdata;
                REG_VERSION: cfg_reg.version    <= pwdata[7:0];
                REG_IMAGE:   cfg_reg.image_type <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAGIC:   prdata = cfg_reg.magic;
            REG_VERSION: prdata = {24'd0, cfg_reg.version};
            REG_IMAGE:   prdata = {24'd0, cfg_reg.image_type};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

[rtl/cpd_parser.sv]
// Header tracker and checker: stores header bytes, checks the header,
// counts payload bytes and forms one result per checksum or payload byte. Depends on cpd_pkg.
module cpd_parser
    import cpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [4:0] LAST_POS = 5'(HDR_BODY);

    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic        pay_reg, pay_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  hdr_reg [HDR_BODY];

    logic        hdr_wr;
    logic [7:0]  mtype;
    logic [31:0] idx, tot, len, magic;
    logic        fin_base;
    cause_t      cause;

    assign mtype    = hdr_reg[5];
    assign magic    = {hdr_reg[0], hdr_reg[1], hdr_reg[2], hdr_reg[3]};
    assign idx      = {hdr_reg[6], hdr_reg[7], hdr_reg[8], hdr_reg[9]};
    assign tot      = {hdr_reg[10], hdr_reg[11], hdr_reg[12], hdr_reg[13]};
    assign len      = {hdr_reg[14], hdr_reg[15], hdr_reg[16], hdr_reg[17]};
    assign fin_base = (mtype == cfg.image_type) && (idx + 32'd1 == tot);

    always_comb
    begin
        if (xor_reg != data_byte)
            cause = CAUSE_CHECKSUM;
        else if (magic != cfg.magic)
            cause = CAUSE_MAGIC;
        else if (hdr_reg[4] != cfg.version)
            cause = CAUSE_VERSION;
        else
            cause = CAUSE_NONE;
    end

    always_comb
    begin
        pos_next  = pos_reg;
        xor_next  = xor_reg;
        pay_next  = pay_reg;
        rem_next  = rem_reg;
        hdr_wr    = 1'b0;
        res_valid = 1'b0;

        res.kind              = KIND_PAYLOAD;
        res.cause             = CAUSE_NONE;
        res.message_type      = mtype;
        res.chunk_index       = idx;
        res.chunk_total       = tot;
        res.payload_length    = len;
        res.final_chunk       = fin_base;
        res.payload_value     = 8'd0;
        res.last_payload_byte = 1'b0;

        if (pay_reg)
        begin
            res_valid             = take;
            res.payload_value     = data_byte;
            res.last_payload_byte = (rem_reg == 32'd1);
            if (take)
            begin
                rem_next = rem_reg - 32'd1;
                if (rem_reg == 32'd1)
                begin
                    pay_next = 1'b0;
                    pos_next = 5'd0;
                    xor_next = 8'd0;
                end
            end
        end
        else if (pos_reg < LAST_POS)
        begin
            if (take)
            begin
                hdr_wr   = 1'b1;
                xor_next = xor_reg ^ data_byte;
                pos_next = pos_reg + 5'd1;
            end
        end
        else
        begin
            res_valid = take;
            res.cause = cause;
            if (cause != CAUSE_NONE)
            begin
                res.kind        = KIND_REJECT;
                res.final_chunk = 1'b0;
            end
            else
            begin
                res.kind = KIND_GOOD;
            end
            if (take)
            begin
                pos_next = 5'd0;
                xor_next = 8'd0;
                if (cause == CAUSE_NONE)
                begin
                    rem_next = len;
                    pay_next = (len != 32'd0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 5'd0;
            xor_reg <= 8'd0;
            pay_reg <= 1'b0;
            rem_reg <= 32'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
            pay_reg <= pay_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HDR_BODY; i++)
        begin
            if (hdr_wr && pos_reg == 5'(i))
                hdr_reg[i] <= data_byte;
        end
    end

endmodule

[rtl/cpd_out_reg.sv]
// Result register with valid/ready handshake toward the receiver.
// Depends on cpd_pkg.
module cpd_out_reg
    import cpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    free,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

[rtl/chunk_packet_deframer.sv]
// Chunk packet deframer: turns a byte stream into header and payload results.
// Byte input channel: in_valid/in_ready with data_byte, one byte per transaction.
// Result channel: out_valid/out_ready with the decoded result fields.
// Each packet is a 19-byte big-endian header (magic, version, type, index,
// total, length, XOR checksum) and then the payload bytes.
// The first 18 header bytes give no result. The checksum byte gives one header
// result, good or rejected with its first failed check; a rejected header is
// dropped and the next byte starts a new header. Each payload byte gives one
// result, the final one marked.
// Throughput: one byte per cycle while out_ready stays high. Latency: a result appears in the
// output register the cycle after its byte is accepted.
// Stall: while a result waits and out_ready is low, in_ready is low; with
// out_ready high a new byte is taken in the same cycle the old result leaves.
// Reset (rst_n low, asynchronous) clears the output valid flag and starts
// hunting for a header; configuration returns to its defaults.
// Configuration: APB-style, registers at 0x0 magic, 0x4 version, 0x8 image type.
module chunk_packet_deframer
    import cpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [1:0]  reject_cause,
    output logic [7:0]  message_type,
    output logic [31:0] chunk_index,
    output logic [31:0] chunk_total,
    output logic [31:0] payload_length,
    output logic        final_chunk,
    output logic [7:0]  payload_value,
    output logic        last_payload_byte
);

    cfg_t    cfg;
    result_t res;
    result_t out_res;
    logic    res_valid;
    logic    take;

    assign pready = 1'b1;
    assign take   = in_valid && in_ready;

    cpd_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .cfg    (cfg)
    );

    cpd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .data_byte(data_byte),
        .cfg      (cfg),
        .res_valid(res_valid),
        .res      (res)
    );

    cpd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .out_ready(out_ready),
        .free     (in_ready),
        .out_valid(out_valid),
        .out_res  (out_res)
    );

    assign out_kind          = out_res.kind;
    assign reject_cause      = out_res.cause;
    assign message_type      = out_res.message_type;
    assign chunk_index       = out_res.chunk_index;
    assign chunk_total       = out_res.chunk_total;
    assign payload_length    = out_res.payload_length;
    assign final_chunk       = out_res.final_chunk;
    assign payload_value     = out_res.payload_value;
    assign last_payload_byte = out_res.last_payload_byte;

endmodule

[rtl/cpd_checker.sv]
// Port-level checks of the chunk packet deframer, bound to the top level.
// Depends on cpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpd_checker
    import cpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [1:0]  reject_cause,
    input logic [31:0] chunk_index,
    input logic        final_chunk,
    input logic [7:0]  payload_value,
    input logic        last_payload_byte
);

    `CPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_kind) && $stable(chunk_index) && $stable(payload_value))

    `CPD_ASSERT_IMPLY(a_hdr_no_payload, clk, rst_n, out_valid && out_kind != KIND_PAYLOAD,
        payload_value == 8'd0 && last_payload_byte == 1'b0)

    `CPD_ASSERT_IMPLY(a_reject_cause, clk, rst_n, out_valid && out_kind == KIND_REJECT,
        reject_cause != CAUSE_NONE && final_chunk == 1'b0)

    `CPD_ASSERT_IMPLY(a_good_no_cause, clk, rst_n,
        out_valid && (out_kind == KIND_GOOD || out_kind == KIND_PAYLOAD),
        reject_cause == CAUSE_NONE)

    `CPD_ASSERT_IMPLY(a_stall_blocks, clk, rst_n, out_valid && !out_ready,
        !in_ready)

endmodule

bind chunk_packet_deframer cpd_checker u_cpd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .reject_cause     (reject_cause),
    .chunk_index      (chunk_index),
    .final_chunk      (final_chunk),
    .payload_value    (payload_value),
    .last_payload_byte(last_payload_byte)
);
